// File: design/spp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_pkg
// Shared widths, types and helpers for the stereo point projection block.
// ----------------------------------------------------------------------------
package spp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int NUM_W     = 2 * DATA_W;          // numerator / quotient width
    localparam int LANES     = 3;                   // u, v, disparity
    localparam int SUM_W     = NUM_W + 2;
    localparam int CLAMP_EXP = 40;
    localparam int CFG_IDX_W = 3;

    localparam int LANE_U  = 0;
    localparam int LANE_V  = 1;
    localparam int LANE_BF = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X   = 3'd0,
        REG_FOCAL_Y   = 3'd1,
        REG_CENTER_X  = 3'd2,
        REG_CENTER_Y  = 3'd3,
        REG_BASELINE  = 3'd4,
        REG_MIN_DEPTH = 3'd5,
        REG_STEREO    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [NUM_W-1:0]  num;   // numerator bits still to shift in
        logic [DATA_W-1:0] rem;   // partial remainder
        logic [NUM_W-1:0]  quo;   // quotient bits so far
    } t_lane;

    typedef struct packed {
        logic              valid;
        logic              invalid;
        logic              neg_x;
        logic              neg_y;
        logic [DATA_W-1:0] z;
        t_lane [LANES-1:0] lane;
    } t_cell;

    typedef struct packed {
        logic [DATA_W-1:0] pixel_u;
        logic [DATA_W-1:0] pixel_v;
        logic [DATA_W-1:0] pixel_u_right;
        logic [DATA_W-1:0] depth;
        logic              valid_res;
    } t_result;

    function automatic logic [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        begin
            hi = SUM_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
            lo = -hi - SUM_W'(1);
            if (s > hi) begin
                sat32 = {1'b0, {(DATA_W-1){1'b1}}};
            end else if (s < lo) begin
                sat32 = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                sat32 = s[DATA_W-1:0];
            end
        end
    endfunction

endpackage

// File: design/spp_pt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_pt_if
// Point channel: one camera-frame point per beat.
// ----------------------------------------------------------------------------
interface spp_pt_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

// File: design/spp_px_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_px_if
// Pixel channel: one projection result per beat.
// ----------------------------------------------------------------------------
interface spp_px_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic signed [31:0] pixel_u_right;
    logic signed [31:0] depth;
    logic        valid_res;

    modport source (output valid, pixel_u, pixel_v, pixel_u_right, depth, valid_res,
                    input ready);
    modport sink   (input valid, pixel_u, pixel_v, pixel_u_right, depth, valid_res,
                    output ready);
endinterface

// File: design/spp_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_div_cell
// One restoring-division step for all lanes; resolves one quotient bit.
// ----------------------------------------------------------------------------
module spp_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  spp_pkg::t_cell i_cell,
    output spp_pkg::t_cell o_cell
);

    spp_pkg::t_cell r_cell;
    spp_pkg::t_cell n_cell;

    always_comb begin
        logic [spp_pkg::DATA_W:0] trial;
        n_cell = i_cell;
        for (int l = 0; l < spp_pkg::LANES; l++) begin
            trial = {i_cell.lane[l].rem, i_cell.lane[l].num[spp_pkg::NUM_W-1]};
            n_cell.lane[l].num = {i_cell.lane[l].num[spp_pkg::NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, i_cell.z}) begin
                trial = trial - {1'b0, i_cell.z};
                n_cell.lane[l].quo = {i_cell.lane[l].quo[spp_pkg::NUM_W-2:0], 1'b1};
            end else begin
                n_cell.lane[l].quo = {i_cell.lane[l].quo[spp_pkg::NUM_W-2:0], 1'b0};
            end
            n_cell.lane[l].rem = trial[spp_pkg::DATA_W-1:0];
        end
    end

    // only the valid bit is reset; payload just follows the enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell.invalid <= n_cell.invalid;
            r_cell.neg_x   <= n_cell.neg_x;
            r_cell.neg_y   <= n_cell.neg_y;
            r_cell.z       <= n_cell.z;
            r_cell.lane    <= n_cell.lane;
        end
    end

    assign o_cell = r_cell;

endmodule

// File: design/spp_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_post
// Clamp, sign, offset and saturate the finished quotients.
// ----------------------------------------------------------------------------
module spp_post (
    input  spp_pkg::t_cell          i_cell,
    input  logic [spp_pkg::DATA_W-1:0] i_center_x,
    input  logic [spp_pkg::DATA_W-1:0] i_center_y,
    input  logic                    i_stereo,
    output spp_pkg::t_result        o_res
);
    localparam logic [spp_pkg::NUM_W-1:0] QCLAMP = spp_pkg::NUM_W'(1) << spp_pkg::CLAMP_EXP;

    logic [spp_pkg::NUM_W-1:0]        q_u, q_v, q_d;
    logic signed [spp_pkg::SUM_W-1:0] s_u, s_v, s_d, sum_u, sum_v, sum_r;

    always_comb begin
        q_u = (i_cell.lane[spp_pkg::LANE_U].quo > QCLAMP) ? QCLAMP
                                                           : i_cell.lane[spp_pkg::LANE_U].quo;
        q_v = (i_cell.lane[spp_pkg::LANE_V].quo > QCLAMP) ? QCLAMP
                                                           : i_cell.lane[spp_pkg::LANE_V].quo;
        q_d = (i_cell.lane[spp_pkg::LANE_BF].quo > QCLAMP) ? QCLAMP
                                                            : i_cell.lane[spp_pkg::LANE_BF].quo;
        s_u = signed'({2'b00, q_u});
        s_v = signed'({2'b00, q_v});
        s_d = signed'({2'b00, q_d});
        if (i_cell.neg_x) s_u = -s_u;
        if (i_cell.neg_y) s_v = -s_v;
        sum_u = s_u + spp_pkg::SUM_W'(signed'(i_center_x));
        sum_v = s_v + spp_pkg::SUM_W'(signed'(i_center_y));
        sum_r = sum_u - s_d;

        o_res.depth = i_cell.z;
        if (i_cell.invalid) begin
            o_res.pixel_u       = spp_pkg::DATA_W'(-(64'sd1 <<< spp_pkg::FRAC_BITS));
            o_res.pixel_v       = o_res.pixel_u;
            o_res.pixel_u_right = o_res.pixel_u;
            o_res.valid_res     = 1'b0;
        end else begin
            o_res.pixel_u       = spp_pkg::sat32(sum_u);
            o_res.pixel_v       = spp_pkg::sat32(sum_v);
            o_res.pixel_u_right = i_stereo ? spp_pkg::sat32(sum_r) : '0;
            o_res.valid_res     = 1'b1;
        end
    end

endmodule

// File: design/pinhole_stereo_point_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_stereo_point_projection
// Pinhole projection of camera-frame points to pixel coordinates, with an
// optional right-image column for a rectified stereo pair.
// ----------------------------------------------------------------------------
// Usage:
//   i_pt  : point beats (X, Y, Z, signed Q16.16), valid/ready.
//   o_px  : result beats (u, v, u_right, depth, valid_res), valid/ready.
//   cfg   : i_cfg_we / i_cfg_idx / i_cfg_data write port; write only when idle.
// Pipeline: input beat to result beat through 1 multiply stage, a
//   chain of 64 divide cells resolving one quotient bit each, and 1 output reg.
// Throughput: one point per cycle when not stalled; the pipe holds 66 points in flight.
// Stall: the whole pipe freezes while the output register holds an untaken
//   result, so i_pt.ready follows (!o_px.valid || o_px.ready).
// Reset: synchronous, active low; empties the pipe and loads register
//   defaults (min_depth = 655, i.e. about 0.01, everything else zero).
// Points at or below min_depth report -1.0 coordinates and valid_res = 0.
// ----------------------------------------------------------------------------
module pinhole_stereo_point_projection (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    spp_pt_if.sink               i_pt,
    spp_px_if.source             o_px,
    input  logic                 i_cfg_we,
    input  logic [spp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [spp_pkg::DATA_W-1:0]    i_cfg_data
);
    localparam int NCELLS = spp_pkg::NUM_W;

    // configuration registers
    logic [spp_pkg::DATA_W-1:0] r_focal_x, r_focal_y, r_center_x, r_center_y, r_baseline;
    logic [spp_pkg::DATA_W-2:0] r_min_depth;
    logic                       r_stereo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x   <= '0;
            r_focal_y   <= '0;
            r_center_x  <= '0;
            r_center_y  <= '0;
            r_baseline  <= '0;
            r_min_depth <= (spp_pkg::DATA_W-1)'(655);
            r_stereo    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (spp_pkg::t_reg_idx'(i_cfg_idx))
                spp_pkg::REG_FOCAL_X:   r_focal_x   <= i_cfg_data;
                spp_pkg::REG_FOCAL_Y:   r_focal_y   <= i_cfg_data;
                spp_pkg::REG_CENTER_X:  r_center_x  <= i_cfg_data;
                spp_pkg::REG_CENTER_Y:  r_center_y  <= i_cfg_data;
                spp_pkg::REG_BASELINE:  r_baseline  <= i_cfg_data;
                spp_pkg::REG_MIN_DEPTH: r_min_depth <= i_cfg_data[spp_pkg::DATA_W-2:0];
                spp_pkg::REG_STEREO:    r_stereo    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipe enable: advance whenever the output slot is free or draining
    logic w_en;
    logic r_out_valid;
    assign w_en       = !r_out_valid || o_px.ready;
    assign i_pt.ready = w_en;

    // front stage: magnitudes, focal products, depth test
    logic [spp_pkg::DATA_W-1:0] w_mag_x, w_mag_y;
    spp_pkg::t_cell n_front, r_front;

    always_comb begin
        w_mag_x = i_pt.point_x[spp_pkg::DATA_W-1] ? -i_pt.point_x : i_pt.point_x;
        w_mag_y = i_pt.point_y[spp_pkg::DATA_W-1] ? -i_pt.point_y : i_pt.point_y;
        n_front.valid   = i_pt.valid;
        n_front.invalid = i_pt.point_z <= signed'({1'b0, r_min_depth});
        n_front.neg_x   = i_pt.point_x[spp_pkg::DATA_W-1];
        n_front.neg_y   = i_pt.point_y[spp_pkg::DATA_W-1];
        n_front.z       = i_pt.point_z;
        for (int l = 0; l < spp_pkg::LANES; l++) begin
            n_front.lane[l].rem = '0;
            n_front.lane[l].quo = '0;
        end
        n_front.lane[spp_pkg::LANE_U].num  = spp_pkg::NUM_W'(r_focal_x) *
                                             spp_pkg::NUM_W'(w_mag_x);
        n_front.lane[spp_pkg::LANE_V].num  = spp_pkg::NUM_W'(r_focal_y) *
                                             spp_pkg::NUM_W'(w_mag_y);
        n_front.lane[spp_pkg::LANE_BF].num = spp_pkg::NUM_W'(r_baseline) << spp_pkg::FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
        end else if (w_en) begin
            r_front.valid <= n_front.valid;
        end
        if (w_en) begin
            r_front.invalid <= n_front.invalid;
            r_front.neg_x   <= n_front.neg_x;
            r_front.neg_y   <= n_front.neg_y;
            r_front.z       <= n_front.z;
            r_front.lane    <= n_front.lane;
        end
    end

    // divide chain: cell k settles quotient bit (NCELLS-1-k)
    spp_pkg::t_cell w_chain [NCELLS+1];
    assign w_chain[0] = r_front;

    for (genvar k = 0; k < NCELLS; k++) begin : g_cell
        spp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cell  (w_chain[k]),
            .o_cell  (w_chain[k+1])
        );
    end

    // final offset / saturation and output register
    spp_pkg::t_result w_res, r_res;

    spp_post u_post (
        .i_cell     (w_chain[NCELLS]),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_stereo   (r_stereo),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_chain[NCELLS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res <= w_res;
        end
    end

    assign o_px.valid         = r_out_valid;
    assign o_px.pixel_u       = r_res.pixel_u;
    assign o_px.pixel_v       = r_res.pixel_v;
    assign o_px.pixel_u_right = r_res.pixel_u_right;
    assign o_px.depth         = r_res.depth;
    assign o_px.valid_res     = r_res.valid_res;

`ifndef ASSERT_OFF
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pt.ready == (!o_px.valid || o_px.ready))
        else $error("input ready does not track output slot");

    a_invalid_minus_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_px.valid && !o_px.valid_res) |->
            (o_px.pixel_u == o_px.pixel_v && o_px.pixel_u == o_px.pixel_u_right))
        else $error("invalid point without matching -1.0 outputs");

    a_valid_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_px.valid && o_px.valid_res) |-> (o_px.depth > signed'({1'b0, r_min_depth})))
        else $error("valid result at or below min_depth");

    a_mono_right_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_px.valid && o_px.valid_res && !r_stereo) |-> (o_px.pixel_u_right == 0))
        else $error("monocular result with nonzero right column");
`endif

endmodule
